@@ rtl/core/mett_pkg.sv @@
// ----------------------------------------------------------------------------
// mett_pkg
// Shared types and constants for the motion event threshold table.
// ----------------------------------------------------------------------------
package mett_pkg;

  localparam int unsigned DefTableEntries = 16;
  localparam int unsigned MaxResults      = 16;
  localparam int unsigned OpW             = 2;
  localparam int unsigned StatusW         = 2;
  localparam int unsigned IdW             = 31;
  localparam int unsigned AxisW           = 22;
  localparam int unsigned CountW          = 8;
  localparam int unsigned ResCntW         = $clog2(MaxResults + 1);

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_LOOKUP = 2'd3
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NO_MATCH  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [AxisW-1:0]  x;
    logic [AxisW-1:0]  y;
    logic [AxisW-1:0]  z;
    logic [CountW-1:0] count;
  } entry_t;

  typedef struct packed {
    logic id_eq;
    logic thr_met;
  } cmp_t;

endpackage

@@ rtl/core/mett_store.sv @@
// ----------------------------------------------------------------------------
// mett_store
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mett_store #(
  parameter int unsigned Entries = mett_pkg::DefTableEntries
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(Entries)-1:0]   wr_addr_i,
  input  mett_pkg::entry_t             wr_data_i,
  input  logic [$clog2(Entries)-1:0]   rd_addr_i,
  output mett_pkg::entry_t             rd_data_o
);
  import mett_pkg::*;

  entry_t mem_q [Entries];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/mett_match.sv @@
// ----------------------------------------------------------------------------
// mett_match
// Shared compare unit: id equality and the four threshold tests.
// ----------------------------------------------------------------------------
module mett_match (
  input  mett_pkg::entry_t entry_i,
  input  mett_pkg::entry_t key_i,
  output mett_pkg::cmp_t   cmp_o
);
  import mett_pkg::*;

  always_comb begin
    cmp_o.id_eq   = (key_i.id == entry_i.id);
    cmp_o.thr_met = (key_i.x >= entry_i.x) && (key_i.y >= entry_i.y) &&
                    (key_i.z >= entry_i.z) && (key_i.count >= entry_i.count);
  end

endmodule

@@ rtl/core/motion_event_threshold_table.sv @@
// ----------------------------------------------------------------------------
// motion_event_threshold_table
// Ordered table of motion events with add, remove, lookup and check requests.
// ----------------------------------------------------------------------------
// One request at a time. An add writes the store on acceptance and then places
// its result in the output register. Lookup, remove and check walk the table
// through the single read port of the entry store, one entry per cycle (a check
// holds while a new match cannot be handed on to a stalled output side); a
// remove then compacts the table by moving each later entry down by one. The
// input is stalled from acceptance until the last result of the request has
// been placed in the output register.
// ----------------------------------------------------------------------------
module motion_event_threshold_table #(
  parameter int unsigned TABLE_ENTRIES = mett_pkg::DefTableEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mett_pkg::OpW-1:0]      opcode_i,
  input  logic [mett_pkg::IdW-1:0]      event_id_i,
  input  logic [mett_pkg::AxisW-1:0]    value_x_i,
  input  logic [mett_pkg::AxisW-1:0]    value_y_i,
  input  logic [mett_pkg::AxisW-1:0]    value_z_i,
  input  logic [mett_pkg::CountW-1:0]   value_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mett_pkg::StatusW-1:0]  status_o,
  output logic [mett_pkg::IdW-1:0]      match_id_o,
  output logic [mett_pkg::AxisW-1:0]    found_x_o,
  output logic [mett_pkg::AxisW-1:0]    found_y_o,
  output logic [mett_pkg::AxisW-1:0]    found_z_o,
  output logic [mett_pkg::CountW-1:0]   found_count_o,
  output logic                          last_o
);
  import mett_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_SHIFT,
    S_EMIT
  } state_e;

  state_e               state_q, state_d;
  opcode_e              op_q, op_d;
  entry_t               key_q, key_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      total_q, total_d;
  logic [ResCntW-1:0]   nres_q, nres_d;
  logic                 pend_q, pend_d;
  logic [IdW-1:0]       pend_id_q, pend_id_d;
  status_e              res_status_q, res_status_d;
  entry_t               res_entry_q, res_entry_d;
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  entry_t               out_entry_q, out_entry_d;
  logic                 out_last_q, out_last_d;

  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  entry_t               wr_data;
  logic [IdxW-1:0]      rd_addr;
  entry_t               rd_data;
  cmp_t                 cmp;

  logic                 out_free;
  logic [CntW-1:0]      idx_p1;
  logic                 at_end;
  logic                 take;
  entry_t               in_entry;

  mett_store #(
    .Entries (TABLE_ENTRIES)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  mett_match u_match (
    .entry_i (rd_data),
    .key_i   (key_q),
    .cmp_o   (cmp)
  );

  assign in_entry = '{id: event_id_i, x: value_x_i, y: value_y_i, z: value_z_i,
                      count: value_count_i};
  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_p1   = CntW'(idx_q) + CntW'(1);
  assign at_end   = (idx_p1 == total_q);
  assign take     = cmp.thr_met && (nres_q < ResCntW'(MaxResults));

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    idx_d        = idx_q;
    total_d      = total_q;
    nres_d       = nres_q;
    pend_d       = pend_q;
    pend_id_d    = pend_id_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_last_d   = out_last_q;
    rd_addr      = idx_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = rd_data;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d        = opcode_e'(opcode_i);
          key_d       = in_entry;
          idx_d       = '0;
          nres_d      = '0;
          pend_d      = 1'b0;
          rd_addr     = '0;
          res_entry_d = '0;
          unique case (opcode_e'(opcode_i))
            OP_ADD: begin
              if (total_q >= CntW'(TABLE_ENTRIES)) begin
                res_status_d = ST_FULL;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = total_q[IdxW-1:0];
                wr_data      = in_entry;
                total_d      = total_q + CntW'(1);
                res_status_d = ST_OK;
              end
              state_d = S_EMIT;
            end
            OP_REMOVE, OP_LOOKUP: begin
              if (total_q == '0) begin
                res_status_d = ST_NOT_FOUND;
                state_d      = S_EMIT;
              end else begin
                state_d = S_TEST;
              end
            end
            OP_CHECK: begin
              if (total_q == '0) begin
                res_status_d = ST_NO_MATCH;
                state_d      = S_EMIT;
              end else begin
                state_d = S_TEST;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_TEST: begin
        unique case (op_q)
          OP_LOOKUP: begin
            if (cmp.id_eq) begin
              res_status_d = ST_OK;
              res_entry_d  = rd_data;
              state_d      = S_EMIT;
            end else if (at_end) begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_EMIT;
            end else begin
              idx_d   = idx_q + IdxW'(1);
              rd_addr = idx_q + IdxW'(1);
            end
          end
          OP_REMOVE: begin
            if (cmp.id_eq) begin
              if (idx_p1 < total_q) begin
                rd_addr = idx_q + IdxW'(1);
                state_d = S_SHIFT;
              end else begin
                total_d      = total_q - CntW'(1);
                res_status_d = ST_OK;
                state_d      = S_EMIT;
              end
            end else if (at_end) begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_EMIT;
            end else begin
              idx_d   = idx_q + IdxW'(1);
              rd_addr = idx_q + IdxW'(1);
            end
          end
          OP_CHECK: begin
            // a new match must wait while the previous one cannot be handed on
            if (!(take && pend_q && !out_free)) begin
              if (take) begin
                if (pend_q) begin
                  out_valid_d  = 1'b1;
                  out_status_d = ST_OK;
                  out_entry_d  = '0;
                  out_entry_d.id = pend_id_q;
                  out_last_d   = 1'b0;
                end
                pend_d    = 1'b1;
                pend_id_d = rd_data.id;
                nres_d    = nres_q + ResCntW'(1);
              end
              if (at_end) begin
                if (pend_q || take) begin
                  res_status_d   = ST_OK;
                  res_entry_d    = '0;
                  res_entry_d.id = take ? rd_data.id : pend_id_q;
                end else begin
                  res_status_d = ST_NO_MATCH;
                end
                state_d = S_EMIT;
              end else begin
                idx_d   = idx_q + IdxW'(1);
                rd_addr = idx_q + IdxW'(1);
              end
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_data;
        idx_d   = idx_q + IdxW'(1);
        if ((idx_p1 + CntW'(1)) < total_q) begin
          rd_addr = idx_q + IdxW'(2);
        end else begin
          total_d      = total_q - CntW'(1);
          res_status_d = ST_OK;
          state_d      = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_entry_d  = res_entry_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_ADD;
      key_q        <= '0;
      idx_q        <= '0;
      total_q      <= '0;
      nres_q       <= '0;
      pend_q       <= 1'b0;
      pend_id_q    <= '0;
      res_status_q <= ST_OK;
      res_entry_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_entry_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      key_q        <= key_d;
      idx_q        <= idx_d;
      total_q      <= total_d;
      nres_q       <= nres_d;
      pend_q       <= pend_d;
      pend_id_q    <= pend_id_d;
      res_status_q <= res_status_d;
      res_entry_q  <= res_entry_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_entry_q  <= out_entry_d;
      out_last_q   <= out_last_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign match_id_o    = out_entry_q.id;
  assign found_x_o     = out_entry_q.x;
  assign found_y_o     = out_entry_q.y;
  assign found_z_o     = out_entry_q.z;
  assign found_count_o = out_entry_q.count;
  assign last_o        = out_last_q;

  // table occupancy stays within the store
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(TABLE_ENTRIES))
    else $error("entry total beyond table size");

  // occupancy moves by one at most per request
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(total_q) |-> (total_q == $past(total_q) + CntW'(1)) ||
                          (total_q == $past(total_q) - CntW'(1)))
    else $error("entry total jumped");

  // store writes only from an add or during compaction
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_IDLE && in_valid_i) || state_q == S_SHIFT)
    else $error("unexpected store write");

  // only check matches are followed by further results
  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_status_q == ST_OK && op_q == OP_CHECK)
    else $error("non-final result outside a check");

  // an accepted request takes the controller out of idle, so the input side is stalled
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != S_IDLE)
    else $error("request accepted without leaving idle");

endmodule
